// File: rtl/smcp_pkg.sv
package smcp_pkg;

   // result port shape, fixed by the command format
   localparam int OUT_SPEEDS = 4;
   localparam int OUT_BITS   = 16;

   // command kinds as reported on the result port
   typedef enum logic [1:0] {
      KIND_TOGGLE  = 2'd0,
      KIND_SPEEDS  = 2'd1,
      KIND_OFF     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   // ascii characters of the command syntax
   localparam logic [7:0] CHAR_END    = 8'h3B;  // ';'
   localparam logic [7:0] CHAR_RELAY  = 8'h52;  // 'R'
   localparam logic [7:0] CHAR_SPEEDS = 8'h57;  // 'W'
   localparam logic [7:0] CHAR_OFF    = 8'h44;  // 'D'
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
   localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'

   // one finished message as handed from the parser to the output register
   typedef struct packed {
      logic                                 relay_on;
      logic [OUT_SPEEDS-1:0][OUT_BITS-1:0]  speed;
      kind_type                             kind;
   } result_type;

endpackage

// File: rtl/smcp_parse.sv
module smcp_parse
   import smcp_pkg::*;
#(
   parameter int VALUE_BITS   = 16,
   parameter int SPEED_FIELDS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       is_end,
   output result_type result
);

   localparam int FN_W = $clog2(SPEED_FIELDS + 1);

   // parser state
   logic                  relay_ff, relay_in;
   logic                  start_ff, start_in;
   kind_type              cmd_ff, cmd_in;
   logic [FN_W-1:0]       fnum_ff, fnum_in;
   logic                  fstart_ff, fstart_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] speed_ff [SPEED_FIELDS];
   logic [VALUE_BITS-1:0] speed_in [SPEED_FIELDS];

   logic [VALUE_BITS-1:0] acc_digit;
   logic [VALUE_BITS-1:0] commit_val;
   logic                  do_commit;
   kind_type              kind_out;
   logic [OUT_BITS-1:0]   speed_out [OUT_SPEEDS];

   assign is_end = (rx_byte == CHAR_END);

   // acc * 10 + digit, wrapping at the value width
   assign acc_digit  = (acc_ff << 3) + (acc_ff << 1) + VALUE_BITS'(rx_byte)
                       - VALUE_BITS'(CHAR_ZERO);
   assign commit_val = neg_ff ? (VALUE_BITS'(0) - acc_ff) : acc_ff;

   // per-byte next state
   always_comb begin
      relay_in  = relay_ff;
      start_in  = start_ff;
      cmd_in    = cmd_ff;
      fnum_in   = fnum_ff;
      fstart_in = fstart_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      do_commit = 1'b0;
      kind_out  = KIND_UNKNOWN;
      if (!is_end) begin
         if (start_ff) begin
            start_in = 1'b0;
            if (rx_byte == CHAR_RELAY) begin
               cmd_in = KIND_TOGGLE;
            end else if (rx_byte == CHAR_SPEEDS) begin
               cmd_in = KIND_SPEEDS;
            end else if (rx_byte == CHAR_OFF) begin
               cmd_in = KIND_OFF;
            end else begin
               cmd_in = KIND_UNKNOWN;
            end
            fnum_in   = '0;
            fstart_in = 1'b1;
            neg_in    = 1'b0;
            acc_in    = '0;
         end else if (cmd_ff == KIND_SPEEDS) begin
            if (fstart_ff && rx_byte == CHAR_MINUS) begin
               neg_in    = 1'b1;
               fstart_in = 1'b0;
            end else if (rx_byte == CHAR_COMMA) begin
               do_commit = 1'b1;
               if (fnum_ff < FN_W'(SPEED_FIELDS)) begin
                  fnum_in = fnum_ff + 1'b1;
               end
               fstart_in = 1'b1;
               neg_in    = 1'b0;
               acc_in    = '0;
            end else begin
               acc_in    = acc_digit;
               fstart_in = 1'b0;
            end
         end
      end else begin
         if (!start_ff) begin
            case (cmd_ff)
               KIND_TOGGLE: relay_in  = ~relay_ff;
               KIND_OFF:    relay_in  = 1'b0;
               KIND_SPEEDS: do_commit = 1'b1;
               default:     ;
            endcase
            kind_out = cmd_ff;
         end
         start_in  = 1'b1;
         cmd_in    = KIND_UNKNOWN;
         fnum_in   = '0;
         fstart_in = 1'b1;
         neg_in    = 1'b0;
         acc_in    = '0;
      end
   end

   // store the finished field into its slot
   always_comb begin
      for (int i = 0; i < SPEED_FIELDS; i++) begin
         speed_in[i] = speed_ff[i];
         if (do_commit && fnum_ff == FN_W'(i)) begin
            speed_in[i] = commit_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff  <= 1'b0;
         start_ff  <= 1'b1;
         cmd_ff    <= KIND_UNKNOWN;
         fnum_ff   <= '0;
         fstart_ff <= 1'b1;
         neg_ff    <= 1'b0;
         acc_ff    <= '0;
         for (int i = 0; i < SPEED_FIELDS; i++) begin
            speed_ff[i] <= '0;
         end
      end else if (step) begin
         relay_ff  <= relay_in;
         start_ff  <= start_in;
         cmd_ff    <= cmd_in;
         fnum_ff   <= fnum_in;
         fstart_ff <= fstart_in;
         neg_ff    <= neg_in;
         acc_ff    <= acc_in;
         for (int i = 0; i < SPEED_FIELDS; i++) begin
            speed_ff[i] <= speed_in[i];
         end
      end
   end

   // sign extend or cut each stored speed to the port width
   for (genvar g = 0; g < OUT_SPEEDS; g++) begin : g_out
      if (g >= SPEED_FIELDS) begin : g_none
         assign speed_out[g] = '0;
      end else if (VALUE_BITS >= OUT_BITS) begin : g_cut
         assign speed_out[g] = speed_in[g][OUT_BITS-1:0];
      end else begin : g_ext
         assign speed_out[g] = {{(OUT_BITS - VALUE_BITS){speed_in[g][VALUE_BITS-1]}},
                                speed_in[g]};
      end
   end

   always_comb begin
      result.relay_on = relay_in;
      result.kind     = kind_out;
      for (int i = 0; i < OUT_SPEEDS; i++) begin
         result.speed[i] = speed_out[i];
      end
   end

endmodule

// File: rtl/smcp_out.sv
module smcp_out
   import smcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  result_type         result,
   output logic               space,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_relay_on,
   output logic signed [15:0] rsp_speed_one,
   output logic signed [15:0] rsp_speed_two,
   output logic signed [15:0] rsp_speed_three,
   output logic signed [15:0] rsp_speed_servo,
   output logic [1:0]         rsp_command_kind
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // register frees when empty or when its beat leaves this cycle
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_relay_on     = data_ff.relay_on;
   assign rsp_speed_one    = signed'(data_ff.speed[0]);
   assign rsp_speed_two    = signed'(data_ff.speed[1]);
   assign rsp_speed_three  = signed'(data_ff.speed[2]);
   assign rsp_speed_servo  = signed'(data_ff.speed[3]);
   assign rsp_command_kind = data_ff.kind;

endmodule

// File: rtl/serial_motor_command_parser.sv
// A ';' byte waits in the input register until the result register has space,
// then is parsed and loaded into the result register, which drives rsp_valid.
// Throughput: one byte per cycle while no ';' waits on a full result register;
// the parser state lies between the input register and the result register.
// Reset (synchronous, active high): relay off, speeds zero, parser waits for the
// first byte of a message, both registers empty.
module serial_motor_command_parser
   import smcp_pkg::*;
#(
   parameter int VALUE_BITS   = 16,
   parameter int SPEED_FIELDS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_relay_on,
   output logic signed [15:0] rsp_speed_one,
   output logic signed [15:0] rsp_speed_two,
   output logic signed [15:0] rsp_speed_three,
   output logic signed [15:0] rsp_speed_servo,
   output logic [1:0]         rsp_command_kind
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       step;
   logic       is_end;
   logic       space;
   result_type result;

   // a byte moves on unless it ends a message and the result register is full
   assign step      = in_valid_ff && (!is_end || space);
   assign req_ready = !in_valid_ff || step;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   smcp_parse #(
      .VALUE_BITS   (VALUE_BITS),
      .SPEED_FIELDS (SPEED_FIELDS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .is_end  (is_end),
      .result  (result)
   );

   smcp_out u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (step && is_end),
      .result           (result),
      .space            (space),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_relay_on     (rsp_relay_on),
      .rsp_speed_one    (rsp_speed_one),
      .rsp_speed_two    (rsp_speed_two),
      .rsp_speed_three  (rsp_speed_three),
      .rsp_speed_servo  (rsp_speed_servo),
      .rsp_command_kind (rsp_command_kind)
   );

endmodule

// File: rtl/smcp_checker.sv
module smcp_checker
   import smcp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_relay_on,
   input logic signed [15:0] rsp_speed_one,
   input logic signed [15:0] rsp_speed_two,
   input logic signed [15:0] rsp_speed_three,
   input logic signed [15:0] rsp_speed_servo,
   input logic [1:0]         rsp_command_kind
);

   logic        rsp_fire;
   logic        last_relay_ff;
   logic [63:0] last_speed_ff;
   logic [63:0] speeds;
   logic        expect_relay;

   assign rsp_fire = rsp_valid && rsp_ready;
   assign speeds   = {rsp_speed_one, rsp_speed_two, rsp_speed_three, rsp_speed_servo};

   // relay follows the kind of each delivered beat
   assign expect_relay = (rsp_command_kind == KIND_TOGGLE) ? !last_relay_ff :
                         (rsp_command_kind == KIND_OFF)    ? 1'b0 : last_relay_ff;

   // track what the last delivered beat showed
   always_ff @(posedge clock) begin
      if (reset) begin
         last_relay_ff <= 1'b0;
         last_speed_ff <= '0;
      end else if (rsp_fire) begin
         last_relay_ff <= rsp_relay_on;
         last_speed_ff <= speeds;
      end
   end

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(speeds)
         && $stable(rsp_relay_on) && $stable(rsp_command_kind))
      else $error("stalled result changed");

   // relay state is consistent with the command sequence
   a_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_relay_on == expect_relay)
      else $error("relay state does not follow commands");

   // only a speed command moves the setpoints
   a_speeds: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_command_kind != KIND_SPEEDS |-> speeds == last_speed_ff)
      else $error("speeds changed without a speed command");

endmodule

bind serial_motor_command_parser smcp_checker u_smcp_checker (.*);

// File: dv/tb.sv
module tb;
   import smcp_pkg::*;

   localparam int unsigned RANDOM_BYTES = 1150;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned HOLD_AT      = 350;
   localparam int unsigned DRAIN_AT     = 700;
   localparam int unsigned CALM_TAIL    = 150;
   localparam int unsigned SPEED_SLOTS  = 4;

   // one directed beat, with an optional typed-in result for its ';'
   typedef struct packed {
      logic [7:0] data;
      logic       pinned;
      result_type res;
   } step_row_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte     = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic               rsp_relay_on;
   logic signed [15:0] rsp_speed_one;
   logic signed [15:0] rsp_speed_two;
   logic signed [15:0] rsp_speed_three;
   logic signed [15:0] rsp_speed_servo;
   logic [1:0]         rsp_command_kind;

   // parser state as the predictor sees it
   logic        relay_now   = 1'b0;
   logic        msg_start   = 1'b1;
   kind_type    cur_kind    = KIND_UNKNOWN;
   logic [2:0]  field_idx   = 3'd0;
   logic        field_fresh = 1'b1;
   logic        field_neg   = 1'b0;
   logic [15:0] field_acc   = 16'd0;
   logic [15:0] speed_set [SPEED_SLOTS];

   result_type   due_reports [$];
   step_row_type directed_steps [$];
   logic [7:0]   msg_bytes [$];

   int unsigned bytes_sent   = 0;
   int unsigned report_errs  = 0;
   logic        idling       = 1'b1;
   logic        hold_rsp     = 1'b0;

   serial_motor_command_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_relay_on     (rsp_relay_on),
      .rsp_speed_one    (rsp_speed_one),
      .rsp_speed_two    (rsp_speed_two),
      .rsp_speed_three  (rsp_speed_three),
      .rsp_speed_servo  (rsp_speed_servo),
      .rsp_command_kind (rsp_command_kind)
   );

   // clock, period 10
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void start_field();
      field_fresh = 1'b1;
      field_neg   = 1'b0;
      field_acc   = 16'd0;
   endfunction

   // store the field in progress, dropped once every slot is filled
   function automatic void store_field();
      if (field_idx < SPEED_SLOTS) begin
         speed_set[field_idx] = field_neg ? 16'd0 - field_acc : field_acc;
         field_idx = field_idx + 3'd1;
      end
      start_field();
   endfunction

   // advance the parser by one character; returns 1 when a report is due
   function automatic logic parse_byte(input logic [7:0] b, output result_type rep);
      logic done;
      done = 1'b0;
      rep  = '0;
      if (b != CHAR_END) begin
         if (msg_start) begin
            msg_start = 1'b0;
            case (b)
               CHAR_RELAY:  cur_kind = KIND_TOGGLE;
               CHAR_SPEEDS: cur_kind = KIND_SPEEDS;
               CHAR_OFF:    cur_kind = KIND_OFF;
               default:     cur_kind = KIND_UNKNOWN;
            endcase
            field_idx = 3'd0;
            start_field();
         end else if (cur_kind == KIND_SPEEDS) begin
            if (field_fresh && b == CHAR_MINUS) begin
               field_neg   = 1'b1;
               field_fresh = 1'b0;
            end else if (b == CHAR_COMMA) begin
               store_field();
            end else begin
               field_acc   = field_acc * 16'd10 + {8'd0, b} - {8'd0, CHAR_ZERO};
               field_fresh = 1'b0;
            end
         end
      end else begin
         // end of message: apply the command and report
         if (msg_start) begin
            rep.kind = KIND_UNKNOWN;
         end else begin
            if (cur_kind == KIND_TOGGLE)
               relay_now = ~relay_now;
            else if (cur_kind == KIND_OFF)
               relay_now = 1'b0;
            else if (cur_kind == KIND_SPEEDS)
               store_field();
            rep.kind = cur_kind;
         end
         rep.relay_on = relay_now;
         for (int i = 0; i < SPEED_SLOTS; i++)
            rep.speed[i] = speed_set[i];
         msg_start = 1'b1;
         cur_kind  = KIND_UNKNOWN;
         field_idx = 3'd0;
         start_field();
         done = 1'b1;
      end
      return done;
   endfunction

   // ---------------------------------------------------------------- directed table

   function automatic void add_byte(input logic [7:0] b);
      step_row_type row;
      row.data   = b;
      row.pinned = 1'b0;
      row.res    = '0;
      directed_steps.push_back(row);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   // ';' whose report is typed in here rather than predicted
   function automatic void add_end(input logic relay, input logic [15:0] s0,
                                   input logic [15:0] s1, input logic [15:0] s2,
                                   input logic [15:0] s3, input kind_type k);
      step_row_type row;
      row.data         = CHAR_END;
      row.pinned       = 1'b1;
      row.res.relay_on = relay;
      row.res.speed[0] = s0;
      row.res.speed[1] = s1;
      row.res.speed[2] = s2;
      row.res.speed[3] = s3;
      row.res.kind     = k;
      directed_steps.push_back(row);
   endfunction

   function automatic logic [7:0] any_but_end();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_END);
      return b;
   endfunction

   // ---------------------------------------------------------------- sender

   // offer one beat, wait for the handshake, then predict
   task automatic send_byte(input logic [7:0] b, input logic pinned, input result_type pin_rep);
      result_type  rep;
      int unsigned gap;
      gap = 0;
      if (idling && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      bytes_sent++;
      if (parse_byte(b, rep))
         due_reports.push_back(pinned ? pin_rep : rep);
   endtask

   initial begin
      int unsigned pick;
      int unsigned n_fields;
      int unsigned n_digits;
      int unsigned n_tail;
      int unsigned total;
      logic        hold_issued;
      logic        drain_issued;

      hold_issued  = 1'b0;
      drain_issued = 1'b0;
      for (int i = 0; i < SPEED_SLOTS; i++)
         speed_set[i] = 16'd0;

      // directed: empty message, toggle, off with ignored tail, negative and
      // wrapping fields with early end, unknown command, fields past the last
      add_end(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, KIND_UNKNOWN);
      add_text("R");
      add_end(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, KIND_TOGGLE);
      add_text("Dx");
      add_end(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, KIND_OFF);
      add_text("W-1,");
      add_byte(8'hFF);
      add_byte(CHAR_END);
      add_byte(8'h00);
      add_text("R;");
      add_text("W1,2,3,4,5");
      add_end(1'b0, 16'd1, 16'd2, 16'd3, 16'd4, KIND_SPEEDS);
      total = directed_steps.size() + RANDOM_BYTES;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_byte(directed_steps[i].data, directed_steps[i].pinned, directed_steps[i].res);

      // random messages, mostly well formed
      while (bytes_sent < total) begin
         idling = (bytes_sent < total - CALM_TAIL) && ($urandom_range(0, 4) != 0);
         if (!hold_issued && bytes_sent >= HOLD_AT) begin
            hold_issued = 1'b1;
            hold_rsp    = 1'b1;
         end
         // pause until every report is in
         if (!drain_issued && bytes_sent >= DRAIN_AT) begin
            drain_issued = 1'b1;
            req_valid <= 1'b0;
            do
               @(posedge clock);
            while (due_reports.size() != 0);
         end
         msg_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // speed message with signed decimal fields
            msg_bytes.push_back(CHAR_SPEEDS);
            n_fields = $urandom_range(0, 6);
            for (int f = 0; f < n_fields; f++) begin
               if (f != 0)
                  msg_bytes.push_back(CHAR_COMMA);
               if ($urandom_range(0, 3) == 0)
                  msg_bytes.push_back(CHAR_MINUS);
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  n_digits = $urandom_range(1, 5);
               else if (pick < 85)
                  n_digits = 0;
               else
                  n_digits = $urandom_range(6, 10);
               for (int d = 0; d < n_digits; d++) begin
                  if ($urandom_range(0, 19) == 0)
                     msg_bytes.push_back(any_but_end());
                  else
                     msg_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               end
            end
            msg_bytes.push_back(CHAR_END);
         end else if (pick < 85) begin
            // relay, off, unknown or empty, with ignored tail
            if (pick < 60)
               msg_bytes.push_back(CHAR_RELAY);
            else if (pick < 70)
               msg_bytes.push_back(CHAR_OFF);
            else if (pick < 80)
               msg_bytes.push_back(any_but_end());
            if (pick < 80) begin
               n_tail = $urandom_range(0, 3);
               repeat (n_tail) msg_bytes.push_back(any_but_end());
            end
            msg_bytes.push_back(CHAR_END);
         end else begin
            // raw noise, any byte
            n_tail = $urandom_range(1, 8);
            repeat (n_tail) msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
         foreach (msg_bytes[i])
            send_byte(msg_bytes[i], 1'b0, '0);
      end
      req_valid <= 1'b0;

      // wait out the remaining reports
      while (due_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (report_errs == 0 && due_reports.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // ready with random stalls and one long hold-off
   initial begin
      int unsigned stall;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idling && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // compare each report beat with the oldest prediction
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.relay_on = rsp_relay_on;
         got.speed[0] = rsp_speed_one;
         got.speed[1] = rsp_speed_two;
         got.speed[2] = rsp_speed_three;
         got.speed[3] = rsp_speed_servo;
         got.kind     = kind_type'(rsp_command_kind);
         if (due_reports.size() == 0) begin
            if (report_errs < 10)
               $display("unexpected report beat: relay=%0d kind=%0d", got.relay_on, got.kind);
            report_errs++;
         end else begin
            want = due_reports.pop_front();
            if (got !== want) begin
               if (report_errs < 10)
                  $display({"report mismatch: exp relay=%0d speeds=%0d,%0d,%0d,%0d kind=%0d",
                            " | got relay=%0d speeds=%0d,%0d,%0d,%0d kind=%0d"},
                           want.relay_on, $signed(want.speed[0]), $signed(want.speed[1]),
                           $signed(want.speed[2]), $signed(want.speed[3]), want.kind,
                           got.relay_on, $signed(got.speed[0]), $signed(got.speed[1]),
                           $signed(got.speed[2]), $signed(got.speed[3]), got.kind);
               report_errs++;
            end
         end
      end
   end

endmodule
